### design/rucsi_pkg.sv
// shared types, constants and helpers for the unit cube slab intersect block
package rucsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 33;
  localparam int DVD_W     = MAG_W + FRAC_BITS;
  localparam int NCELL     = DVD_W;
  localparam int Q_W       = 33;

  localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } res_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [31:0]      dvs;
    logic [31:0]      rem;
    logic [DVD_W-1:0] dvd;
    logic [Q_W-1:0]   quo;
  } div_t;

  typedef struct packed {
    logic [2:0] par;
    logic [2:0] ent_min;
    logic [2:0] ext_max;
  } side_t;

  function automatic logic signed [31:0] rucsi_sat(input div_t s);
    logic big;
    logic signed [31:0] r;
    if (!s.neg) begin
      big = s.ovf | s.quo[32] | s.quo[31];
      r   = big ? Q_MAX : $signed(s.quo[31:0]);
    end else begin
      big = s.ovf | s.quo[32] | (s.quo[31] & (|s.quo[30:0]));
      r   = big ? Q_MIN : $signed(32'(-s.quo[31:0]));
    end
    return r;
  endfunction

endpackage

### design/rucsi_div_cell.sv
// one restoring division step: one quotient bit per cell, registered
module rucsi_div_cell (
  input  logic          clk_i,
  input  rucsi_pkg::div_t s_i,
  output rucsi_pkg::div_t s_o
);
  import rucsi_pkg::*;

  logic [32:0] trial;
  logic        ge;
  div_t        s_d, s_q;

  always_comb begin
    trial = {s_i.rem, s_i.dvd[DVD_W-1]};
    ge    = trial >= {1'b0, s_i.dvs};
    s_d       = s_i;
    s_d.rem   = ge ? 32'(trial - {1'b0, s_i.dvs}) : trial[31:0];
    s_d.dvd   = {s_i.dvd[DVD_W-2:0], 1'b0};
    s_d.ovf   = s_i.ovf | s_i.quo[Q_W-1];
    s_d.quo   = {s_i.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign s_o = s_q;
endmodule

### design/rucsi_div_chain.sv
// row of division cells, one quotient bit each, passing the partial remainder along
module rucsi_div_chain (
  input  logic          clk_i,
  input  rucsi_pkg::div_t s_i,
  output rucsi_pkg::div_t s_o
);
  import rucsi_pkg::*;

  div_t link [NCELL+1];

  assign link[0] = s_i;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rucsi_div_cell u_cell (
      .clk_i (clk_i),
      .s_i   (link[i]),
      .s_o   (link[i+1])
    );
  end

  assign s_o = link[NCELL];
endmodule

### design/ray_unit_cube_slab_intersect_core.sv
// top level: ray against the unit cube, slab method, fully pipelined
//
// one ray beat is taken on ray_i at every clock edge where start is high;
// busy is held low, so a new ray may follow in every cycle.
// each ray gives one result beat on res_o, marked by done_o for one cycle.
// from the accepting edge a ray runs through six parallel rows of division
// cells, one registered cell per quotient bit, then saturate and order, then
// the min/max over the axes, then the hit compare, each registered in turn.
// throughput is one ray per cycle.
// results leave in order and cannot be held off; the sink must take each beat.
// parallel_threshold sits at byte address 0 on the apb port and resets to 7;
// write it only while no ray is in flight.
// reset clears the valid pipeline and the register; payload stages are not reset.
module ray_unit_cube_slab_intersect_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rucsi_pkg::ray_t  ray_i,
  output logic             done_o,
  output rucsi_pkg::res_t  res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rucsi_pkg::*;

  logic [15:0] thr_q;
  logic        acc;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = {16'b0, thr_q};
  assign acc    = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd7;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      thr_q <= pwdata[15:0];
    end
  end

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  div_t               dv_in  [6];
  div_t               dv_out [6];
  side_t              side_in;

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  for (genvar a = 0; a < 3; a++) begin : g_prep
    logic signed [33:0] lo, hi;
    logic [33:0]        lo_m, hi_m;
    logic [31:0]        dmag;
    always_comb begin
      lo   = -ONE_Q - 34'(org[a]);
      hi   = ONE_Q - 34'(org[a]);
      lo_m = lo[33] ? 34'(-lo) : lo;
      hi_m = hi[33] ? 34'(-hi) : hi;
      dmag = dir[a][31] ? 32'(-dir[a]) : dir[a];
      side_in.par[a]     = (dir[a] == 32'sd0) || (dmag < {16'b0, thr_q});
      side_in.ent_min[a] = (lo <= 34'sd0);
      side_in.ext_max[a] = ~hi[33];
      dv_in[2*a]     = '0;
      dv_in[2*a].neg = lo[33] ^ dir[a][31];
      dv_in[2*a].dvs = dmag;
      dv_in[2*a].dvd = {lo_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      dv_in[2*a+1]     = '0;
      dv_in[2*a+1].neg = hi[33] ^ dir[a][31];
      dv_in[2*a+1].dvs = dmag;
      dv_in[2*a+1].dvd = {hi_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_div
    rucsi_div_chain u_chain (
      .clk_i (clk_i),
      .s_i   (dv_in[k]),
      .s_o   (dv_out[k])
    );
  end

  side_t             side_q [NCELL];
  logic [NCELL-1:0]  vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NCELL-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int i = 1; i < NCELL; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // saturate and order per axis
  logic signed [31:0] ent_d [3], ext_d [3], ent_q [3], ext_q [3];
  logic               va_q, vb_q, vc_q;

  for (genvar a = 0; a < 3; a++) begin : g_ord
    logic signed [31:0] qa, qb;
    always_comb begin
      qa = rucsi_sat(dv_out[2*a]);
      qb = rucsi_sat(dv_out[2*a+1]);
      if (side_q[NCELL-1].par[a]) begin
        ent_d[a] = side_q[NCELL-1].ent_min[a] ? Q_MIN : Q_MAX;
        ext_d[a] = side_q[NCELL-1].ext_max[a] ? Q_MAX : Q_MIN;
      end else if (qa > qb) begin
        ent_d[a] = qb;
        ext_d[a] = qa;
      end else begin
        ent_d[a] = qa;
        ext_d[a] = qb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    ext_q <= ext_d;
  end

  // widest entry and narrowest exit over the axes
  logic signed [31:0] tn_d, tf_d, tn_q, tf_q;

  always_comb begin
    tn_d = ent_q[0];
    tf_d = ext_q[0];
    for (int a = 1; a < 3; a++) begin
      if (ent_q[a] > tn_d) tn_d = ent_q[a];
      if (ext_q[a] < tf_d) tf_d = ext_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    tn_q <= tn_d;
    tf_q <= tf_d;
  end

  res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.hit    <= (tn_q <= tf_q);
    res_q.t_near <= tn_q;
    res_q.t_far  <= tf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= vld_q[NCELL-1];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign done_o = vc_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.hit == (res_o.t_near <= res_o.t_far)))
    else $error("hit flag disagrees with distances");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(va_q, 2))
    else $error("result beat without a ray behind it");
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NCELL-1] |=> va_q)
    else $error("ray lost leaving the divider rows");
`endif
endmodule

### tb/tb_ray_unit_cube_slab_intersect_core.sv
// testbench for the unit cube slab intersect block: random and directed rays against a predictor
`timescale 1ns / 100ps

module tb_ray_unit_cube_slab_intersect_core;
  import rucsi_pkg::*;

  localparam int LATENCY = 52;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  ray_t        ray_i;
  logic        done_o;
  res_t        res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ray_unit_cube_slab_intersect_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .ray_i(ray_i),
    .done_o(done_o), .res_o(res_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ray_t        ray_q[$];
  int          gap_q[$];
  res_t        hit_exp_q[$];
  logic [15:0] thresh;
  int          n_err;
  int          n_done;
  int          drv_wait;
  logic        drv_busy;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("ray_unit_cube_slab_intersect_core: mismatch");
    $finish;
  end

  function automatic void slab_range(input logic signed [31:0] o, input logic signed [31:0] d,
                                     output longint ent, output longint ext);
    longint one, lo, hi, mag, a, b, t;
    one = 64'sd1 << FRAC_BITS;
    lo  = -one - longint'(o);
    hi  = one - longint'(o);
    mag = d < 0 ? -longint'(d) : longint'(d);
    if (d == 0 || mag < longint'(thresh)) begin
      ent = lo <= 0 ? -64'sd2147483648 : 64'sd2147483647;
      ext = hi >= 0 ? 64'sd2147483647 : -64'sd2147483648;
    end else begin
      a = (lo * one) / longint'(d);
      b = (hi * one) / longint'(d);
      if (a > 64'sd2147483647) a = 64'sd2147483647;
      if (a < -64'sd2147483648) a = -64'sd2147483648;
      if (b > 64'sd2147483647) b = 64'sd2147483647;
      if (b < -64'sd2147483648) b = -64'sd2147483648;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      ent = a;
      ext = b;
    end
  endfunction

  function automatic res_t cube_hit(input ray_t r);
    longint tn, tf, e, x;
    res_t   p;
    tn = -64'sd2147483648;
    tf = 64'sd2147483647;
    slab_range(r.origin_x, r.dir_x, e, x);
    if (e > tn) tn = e;
    if (x < tf) tf = x;
    slab_range(r.origin_y, r.dir_y, e, x);
    if (e > tn) tn = e;
    if (x < tf) tf = x;
    slab_range(r.origin_z, r.dir_z, e, x);
    if (e > tn) tn = e;
    if (x < tf) tf = x;
    p.hit    = tn <= tf;
    p.t_near = tn[31:0];
    p.t_far  = tf[31:0];
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 16) / 2);
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return 32'h0;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic ray_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  task automatic push_ray(input ray_t r, input bit no_gap);
    ray_q.push_back(r);
    gap_q.push_back(no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0));
  endtask

  task automatic drain();
    while (ray_q.size() != 0 || drv_busy || hit_exp_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!addr[2]) thresh = data[15:0];
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (start && !busy) begin
      hit_exp_q.push_back(cube_hit(ray_i));
    end
    if (done_o) begin
      n_done++;
      if (hit_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("result beat with no ray pending: %p", res_o);
      end else begin
        res_t want;
        want = hit_exp_q.pop_front();
        if (want.hit !== res_o.hit || want.t_near !== res_o.t_near ||
            want.t_far !== res_o.t_far) begin
          n_err++;
          if (n_err <= 10) $display("result beat wrong: expected %p, got %p", want, res_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      drv_wait <= 0;
      drv_busy <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (drv_wait > 0) begin
      start    <= 1'b0;
      drv_wait <= drv_wait - 1;
    end else if (ray_q.size() != 0 && !(start && gap_q[0] != 0)) begin
      start    <= 1'b1;
      ray_i    <= ray_q.pop_front();
      drv_wait <= gap_q.pop_front();
      drv_busy <= 1'b1;
    end else begin
      start    <= 1'b0;
      drv_busy <= 1'b0;
    end
  end

  initial begin
    logic [31:0] th_set[4];
    int          k;
    int          i;
    logic [31:0] ex[6];
    rst_ni = 1'b0; start = 1'b0; ray_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    thresh = 16'd7; n_err = 0; n_done = 0; drv_wait = 0; drv_busy = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    ex = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
    push_ray(mk_ray(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0), 1'b0);
    push_ray(mk_ray(32'hFFFD_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0), 1'b0);
    push_ray(mk_ray(32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0), 1'b0);
    push_ray(mk_ray(32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h1), 1'b0);
    push_ray(mk_ray(32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0), 1'b0);
    push_ray(mk_ray(32'h0, 32'h0, 32'h0002_0000, 32'h6, 32'h0, 32'h0), 1'b0);
    push_ray(mk_ray(32'h0, 32'h0, 32'h0, 32'h7, 32'hFFFF_FFF9, 32'h8), 1'b0);
    push_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7, 32'h8, 32'h1), 1'b0);
    for (i = 0; i < 6; i++) begin
      push_ray(mk_ray(ex[i], ex[(i + 1) % 6], ex[(i + 2) % 6],
                      ex[(i + 3) % 6], ex[(i + 4) % 6], ex[(i + 5) % 6]), 1'b0);
    end
    push_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0);
    push_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1), 1'b0);
    drain();

    th_set = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0100, 32'h1234_0007};
    for (k = 0; k < 4; k++) begin
      apb_write(3'd0, th_set[k]);
      for (i = 0; i < 500; i++) begin
        push_ray(mk_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_dir(), rand_dir(), rand_dir()), i < 60);
      end
      drain();
    end
    apb_write(3'd4, 32'hFFFF_FFFF);
    for (i = 0; i < 100; i++) begin
      push_ray(mk_ray($urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom()), 1'b0);
    end
    drain();

    if (n_err == 0 && hit_exp_q.size() == 0) begin
      $display("ray_unit_cube_slab_intersect_core: match");
    end else begin
      $display("ray_unit_cube_slab_intersect_core: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/rucsi_pkg.sv
design/rucsi_div_cell.sv
design/rucsi_div_chain.sv
design/ray_unit_cube_slab_intersect_core.sv
tb/tb_ray_unit_cube_slab_intersect_core.sv
